// File: rtl/core/drrip_pkg.sv
package drrip_pkg;

	localparam int Sets = 2048;
	localparam int Ways = 16;
	localparam int Leaders = 32;
	localparam int SelBits = 10;
	localparam int AddrBits = 48;
	localparam int SetBits = $clog2(Sets);
	localparam int WayBits = $clog2(Ways);
	localparam int RowBits = 2 * Ways;
	localparam int StrideBits = AddrBits + 1;
	localparam int DetBits = AddrBits + StrideBits + 4;

	localparam logic [SelBits-1:0] SelMid = SelBits'(1) << (SelBits - 1);
	localparam logic [SelBits-1:0] SelMax = '1;
	localparam logic [1:0] RrvDistant = 2'd3;
	localparam logic [1:0] RrvLong = 2'd2;
	localparam logic [1:0] RrvNear = 2'd0;
	localparam logic [3:0] ScoreMax = 4'd15;
	localparam logic [3:0] ThreshReset = 4'd8;

	localparam logic FuncVictim = 1'b0;
	localparam logic FuncUpdate = 1'b1;

	typedef struct packed {
		logic [SetBits-1:0] set_index;
		logic [3:0] way_index;
		logic [15:0] valid_mask;
		logic [AddrBits-1:0] phys_addr;
		logic func;
		logic was_hit;
		logic [4:0] random_bits;
	} req_t;

	typedef struct packed {
		logic [AddrBits-1:0] prev_addr;
		logic [StrideBits-1:0] last_stride;
		logic [3:0] score;
	} det_t;

endpackage

// File: rtl/core/drrip_replacement_with_stream_detect.sv
// Channel | Dir | Transfer when       | Contents
// s_axis  | in  | tvalid && tready    | request fields in tdata/tuser
// m_axis  | out | tvalid && tready    | victim_way, streaming, bypassed
// apb     | in  | psel&penable&pwrite | stream_threshold at address 0
// An item passes through accept, a read of the set row (registered memory),
// compute and write back, then a move of the result into the output register.
// After reset a clearing pass writes all 2048 sets, one per cycle, while
// s_axis_tready stays low. An item waits after write back while the output
// register still holds an untaken result, and s_axis_tready stays low
// until that result moves out.
module drrip_replacement_with_stream_detect (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// tdata: set_index[10:0], way_index[14:11], valid_mask[30:15],
	// phys_addr[78:31], was_hit[79], random_bits[84:80], zero fill
	input logic [87:0] s_axis_tdata,
	// tuser: func
	input logic s_axis_tuser,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// tdata: victim_way[3:0], streaming[4], bypassed[5], zero fill
	output logic [7:0] m_axis_tdata,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import drrip_pkg::*;

	typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_CALC, S_WAIT} state_t;

	state_t state_q;
	logic [SetBits-1:0] clr_q;
	logic [3:0] thresh_q;
	logic [SelBits-1:0] sel_q;
	req_t req_q;
	logic [5:0] res_q;
	logic [5:0] out_q;
	logic out_v_q;

	logic rd_en, wr_en;
	logic [SetBits-1:0] wr_addr;
	logic [RowBits-1:0] rd_row, wr_row, new_row;
	det_t rd_det, wr_det, new_det;
	logic [5:0] res;
	logic [SelBits-1:0] new_sel;

	drrip_mem u_mem (
		.clk(clk), .rd_en(rd_en), .rd_addr(req_q.set_index), .rd_row(rd_row),
		.rd_det(rd_det), .wr_en(wr_en), .wr_addr(wr_addr), .wr_row(wr_row),
		.wr_det(wr_det)
	);

	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {28'd0, thresh_q} : 32'd0;
	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = {2'b00, out_q};
	assign rd_en = (state_q == S_READ);

	// compute on the row read back
	always_comb begin
		logic [1:0] rv [Ways];
		logic [1:0] top, k;
		logic found, st, srrip, byp;
		logic [WayBits-1:0] vw;
		logic [StrideBits-1:0] stride;
		logic [1:0] ins;
		logic [3:0] sc;
		for (int w = 0; w < Ways; w++) rv[w] = rd_row[2*w +: 2];
		new_row = rd_row;
		new_det = rd_det;
		new_sel = sel_q;
		res = '0;
		found = 1'b0;
		vw = '0;
		top = '0;
		k = '0;
		st = 1'b0;
		srrip = 1'b0;
		byp = 1'b0;
		ins = RrvNear;
		sc = rd_det.score;
		stride = '0;
		if (req_q.func == FuncVictim) begin
			for (int w = Ways - 1; w >= 0; w--)
				if (w < 16 && !req_q.valid_mask[w]) begin
					found = 1'b1;
					vw = WayBits'(w);
				end
			if (!found) begin
				for (int w = 0; w < Ways; w++) if (rv[w] > top) top = rv[w];
				k = RrvDistant - top;
				for (int w = 0; w < Ways; w++) begin
					rv[w] = rv[w] + k;
					new_row[2*w +: 2] = rv[w];
				end
				for (int w = Ways - 1; w >= 0; w--)
					if (rv[w] == RrvDistant) vw = WayBits'(w);
			end
			res = {2'b00, 4'(vw)};
		end else begin
			// stride detector
			stride = {1'b0, req_q.phys_addr} - {1'b0, rd_det.prev_addr};
			if (rd_det.prev_addr != '0) begin
				if (stride == rd_det.last_stride && stride != '0) begin
					if (sc < ScoreMax) sc = sc + 4'd1;
				end else if (sc != 4'd0) begin
					sc = sc - 4'd1;
				end
				st = (sc >= thresh_q);
			end
			new_det.score = sc;
			new_det.last_stride = stride;
			new_det.prev_addr = req_q.phys_addr;
			if (req_q.was_hit) begin
				if (32'(req_q.way_index) < Ways) new_row[2*req_q.way_index[WayBits-1:0] +: 2] = RrvNear;
			end else begin
				if (32'(req_q.set_index) < Leaders) begin
					srrip = 1'b1;
					if (sel_q != '0) new_sel = sel_q - SelBits'(1);
				end else if (32'(req_q.set_index) < 2 * Leaders) begin
					if (sel_q != SelMax) new_sel = sel_q + SelBits'(1);
				end else begin
					srrip = (sel_q >= SelMid);
				end
				ins = (srrip || req_q.random_bits == 5'd0) ? RrvNear : RrvLong;
				if (st) begin
					ins = RrvDistant;
					byp = 1'b1;
					for (int w = 0; w < Ways; w++) if (rv[w] < RrvLong) byp = 1'b0;
				end
				if (!byp && 32'(req_q.way_index) < Ways)
					new_row[2*req_q.way_index[WayBits-1:0] +: 2] = ins;
			end
			res = {byp, st, 4'd0};
		end
	end

	// clear pass writes zeros, else write back in calc
	always_comb begin
		wr_en = 1'b0;
		wr_addr = req_q.set_index;
		wr_row = new_row;
		wr_det = new_det;
		if (state_q == S_CLEAR) begin
			wr_en = 1'b1;
			wr_addr = clr_q;
			wr_row = '0;
			wr_det = '0;
		end else if (state_q == S_CALC) begin
			wr_en = 1'b1;
		end
	end

	// sequencer, selector, config and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			thresh_q <= ThreshReset;
			sel_q <= SelMid;
			res_q <= '0;
			out_q <= '0;
			req_q <= '0;
		end else begin
			if (psel && penable && pwrite && paddr == 2'd0) thresh_q <= pwdata[3:0];
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + SetBits'(1);
					if (clr_q == SetBits'(Sets - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (s_axis_tvalid) begin
						req_q.set_index <= s_axis_tdata[10:0];
						req_q.way_index <= s_axis_tdata[14:11];
						req_q.valid_mask <= s_axis_tdata[30:15];
						req_q.phys_addr <= s_axis_tdata[78:31];
						req_q.was_hit <= s_axis_tdata[79];
						req_q.random_bits <= s_axis_tdata[84:80];
						req_q.func <= s_axis_tuser;
						state_q <= S_READ;
					end
				end
				S_READ: state_q <= S_CALC;
				S_CALC: begin
					sel_q <= new_sel;
					res_q <= res;
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (!out_v_q || m_axis_tready) begin
						out_q <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// set output valid on hand-off, drop it once the result is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (state_q == S_WAIT && (!out_v_q || m_axis_tready)) begin
			out_v_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_v_q <= 1'b0;
		end
	end

endmodule

// File: rtl/core/drrip_mem.sv
module drrip_mem (
	input logic clk,
	input logic rd_en,
	input logic [drrip_pkg::SetBits-1:0] rd_addr,
	output logic [drrip_pkg::RowBits-1:0] rd_row,
	output drrip_pkg::det_t rd_det,
	input logic wr_en,
	input logic [drrip_pkg::SetBits-1:0] wr_addr,
	input logic [drrip_pkg::RowBits-1:0] wr_row,
	input drrip_pkg::det_t wr_det
);
	import drrip_pkg::*;

	logic [RowBits-1:0] row_mem [Sets];
	logic [DetBits-1:0] det_mem [Sets];

	// write row and detector state together
	always_ff @(posedge clk) begin
		if (wr_en) begin
			row_mem[wr_addr] <= wr_row;
			det_mem[wr_addr] <= wr_det;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_row <= row_mem[rd_addr];
			rd_det <= det_mem[rd_addr];
		end
	end

endmodule

// File: bench/tb.sv
module tb;
	import drrip_pkg::*;

	localparam logic [1:0] AddrThresh = 2'd0;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [87:0] s_axis_tdata;
	logic s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [7:0] m_axis_tdata;
	logic psel;
	logic penable;
	logic pwrite;
	logic [1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	typedef struct packed {
		logic bypassed;
		logic streaming;
		logic [3:0] victim_way;
	} verdict_t;

	// shadow replacement state
	logic [1:0] rrv_mirror [Sets][Ways];
	logic [AddrBits-1:0] prev_addr_mirror [Sets];
	logic [StrideBits-1:0] last_stride_mirror [Sets];
	logic [3:0] score_mirror [Sets];
	logic [SelBits-1:0] selector_mirror;
	logic [3:0] thresh_mirror;

	verdict_t pending_verdicts [$];
	int errors;
	int verdicts_seen;
	int streams_seen;
	int bypasses_seen;
	int items_sent;

	drrip_replacement_with_stream_detect u_top (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#60000000;
		$display("tb NOT OK");
		$finish;
	end

	task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// compute the expected verdict and advance the shadow state
	function automatic verdict_t predict_verdict(input req_t r);
		verdict_t v;
		logic [StrideBits-1:0] stride;
		logic [1:0] top;
		logic [1:0] ins;
		logic srrip;
		logic found;
		int s;
		v = '0;
		s = int'(r.set_index);
		if (r.func == FuncVictim) begin
			found = 1'b0;
			for (int w = 0; w < Ways; w++) begin
				if (!found && !r.valid_mask[w]) begin
					v.victim_way = 4'(w);
					found = 1'b1;
				end
			end
			if (!found) begin
				top = 2'd0;
				for (int w = 0; w < Ways; w++)
					if (rrv_mirror[s][w] > top) top = rrv_mirror[s][w];
				for (int w = 0; w < Ways; w++)
					rrv_mirror[s][w] = rrv_mirror[s][w] + (RrvDistant - top);
				for (int w = Ways - 1; w >= 0; w--)
					if (rrv_mirror[s][w] == RrvDistant) v.victim_way = 4'(w);
			end
			return v;
		end
		stride = {1'b0, r.phys_addr} - {1'b0, prev_addr_mirror[s]};
		if (prev_addr_mirror[s] != '0) begin
			if (stride == last_stride_mirror[s] && stride != '0) begin
				if (score_mirror[s] < ScoreMax) score_mirror[s]++;
			end else if (score_mirror[s] > 4'd0) begin
				score_mirror[s]--;
			end
			v.streaming = score_mirror[s] >= thresh_mirror;
		end
		last_stride_mirror[s] = stride;
		prev_addr_mirror[s] = r.phys_addr;
		if (r.was_hit) begin
			rrv_mirror[s][r.way_index] = RrvNear;
			return v;
		end
		if (s < Leaders) begin
			srrip = 1'b1;
			if (selector_mirror > '0) selector_mirror--;
		end else if (s < 2 * Leaders) begin
			srrip = 1'b0;
			if (selector_mirror < SelMax) selector_mirror++;
		end else begin
			srrip = selector_mirror >= SelMid;
		end
		ins = (srrip || r.random_bits == 5'd0) ? RrvNear : RrvLong;
		if (v.streaming) begin
			ins = RrvDistant;
			v.bypassed = 1'b1;
			for (int w = 0; w < Ways; w++)
				if (rrv_mirror[s][w] < RrvLong) v.bypassed = 1'b0;
		end
		if (!v.bypassed) rrv_mirror[s][r.way_index] = ins;
		return v;
	endfunction

	// send one transfer and queue its expected verdict
	task automatic send_request(input req_t r);
		int gap;
		gap = $urandom_range(0, 15);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= r.func;
		s_axis_tdata <= {3'b0, r.random_bits, r.was_hit, r.phys_addr, r.valid_mask,
			r.way_index, r.set_index};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_verdicts.push_back(predict_verdict(r));
		items_sent++;
	endtask

	task automatic write_threshold(input logic [3:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= AddrThresh;
		pwdata <= {28'b0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		thresh_mirror = value;
	endtask

	task automatic wait_idle();
		int guard;
		guard = 0;
		s_axis_tvalid <= 1'b0;
		while (pending_verdicts.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		if (guard >= 200000) begin
			$display("tb NOT OK");
			$finish;
		end
		repeat (8) @(posedge clk);
	endtask

	function automatic req_t make_update(input int s, input logic [47:0] a, input logic hit);
		req_t r;
		r = '0;
		r.func = FuncUpdate;
		r.set_index = SetBits'(s);
		r.way_index = 4'($urandom_range(0, 15));
		r.valid_mask = 16'($urandom);
		r.phys_addr = a;
		r.was_hit = hit;
		r.random_bits = 5'($urandom_range(0, 31));
		return r;
	endfunction

	function automatic req_t make_victim(input int s, input logic [15:0] m);
		req_t r;
		r = '0;
		r.func = FuncVictim;
		r.set_index = SetBits'(s);
		r.valid_mask = m;
		r.way_index = 4'($urandom_range(0, 15));
		r.phys_addr = 48'({$urandom, $urandom});
		r.was_hit = 1'($urandom_range(0, 1));
		r.random_bits = 5'($urandom_range(0, 31));
		return r;
	endfunction

	// victim search: invalid ways first, then aging of a full set
	task automatic test_victim_extremes();
		send_request(make_victim(0, 16'h0000));
		send_request(make_victim(Sets - 1, 16'hFFFF));
		send_request(make_victim(100, 16'h7FFF));
		send_request(make_victim(100, 16'hFFFE));
		send_request(make_victim(100, 16'hFFFF));
		send_request(make_victim(100, 16'hFFFF));
	endtask

	// fills in both leader groups and a follower set, plus hits
	task automatic test_policy_fills();
		req_t r;
		r = make_update(5, 48'hFFFF_FFFF_FFFF, 1'b0);
		r.way_index = 4'd15;
		send_request(r);
		r = make_update(Leaders, 48'h1000, 1'b0);
		r.random_bits = 5'd0;
		send_request(r);
		r = make_update(Leaders + 1, 48'h2000, 1'b0);
		r.random_bits = 5'h1F;
		send_request(r);
		send_request(make_update(700, 48'h0, 1'b0));
		send_request(make_update(700, 48'h40, 1'b1));
		send_request(make_victim(700, 16'hFFFF));
	endtask

	// constant stride drives a set to streaming, then a victim search on it
	task automatic test_stream_bypass();
		req_t r;
		for (int i = 1; i <= 12; i++) begin
			r = make_update(900, 48'h10000 + 48'(i * 64), 1'b0);
			r.random_bits = 5'd3;
			send_request(r);
		end
		send_request(make_victim(900, 16'hFFFF));
	endtask

	// random traffic over few sets so strides and selector move
	task automatic test_random_traffic(input int count);
		req_t r;
		logic [47:0] base [8];
		logic [47:0] step [8];
		int k;
		for (int i = 0; i < 8; i++) begin
			base[i] = 48'({$urandom, $urandom});
			step[i] = 48'($urandom_range(1, 4) * 64);
		end
		for (int i = 0; i < count; i++) begin
			k = $urandom_range(0, 7);
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					r = make_victim(k < 4 ? k * 20 : 1000 + k,
						$urandom_range(0, 3) == 0 ? 16'($urandom) : 16'hFFFF);
				end
				3: begin
					r = make_update($urandom_range(0, Sets - 1), 48'({$urandom, $urandom}),
						1'($urandom_range(0, 1)));
				end
				default: begin
					base[k] = base[k] + step[k];
					r = make_update(k < 4 ? k * 20 : 1000 + k, base[k],
						$urandom_range(0, 3) == 0);
				end
			endcase
			send_request(r);
		end
	endtask

	// check each result transfer against the oldest expectation
	always @(posedge clk) begin
		verdict_t got;
		verdict_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[5:0];
			if (pending_verdicts.size() == 0) begin
				report("unexpected", m_axis_tdata, 8'h0);
			end else begin
				want = pending_verdicts.pop_front();
				verdicts_seen++;
				if (want.streaming) streams_seen++;
				if (want.bypassed) bypasses_seen++;
				if (got.victim_way !== want.victim_way)
					report("victim_way", 8'(got.victim_way), 8'(want.victim_way));
				if (got.streaming !== want.streaming)
					report("streaming", 8'(got.streaming), 8'(want.streaming));
				if (got.bypassed !== want.bypassed)
					report("bypassed", 8'(got.bypassed), 8'(want.bypassed));
				if (m_axis_tdata[7:6] !== 2'b0) report("fill bits", m_axis_tdata, 8'h0);
			end
		end
	end

	// random result stalls, with stall-free stretches
	always @(posedge clk) begin
		if (items_sent % 100 < 30) m_axis_tready <= 1'b1;
		else m_axis_tready <= ($urandom_range(0, 15) == 0);
	end

	initial begin
		errors = 0;
		verdicts_seen = 0;
		streams_seen = 0;
		bypasses_seen = 0;
		items_sent = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		m_axis_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		for (int s = 0; s < Sets; s++) begin
			for (int w = 0; w < Ways; w++) rrv_mirror[s][w] = RrvNear;
			prev_addr_mirror[s] = '0;
			last_stride_mirror[s] = '0;
			score_mirror[s] = '0;
		end
		selector_mirror = SelMid;
		thresh_mirror = ThreshReset;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_victim_extremes();
		test_policy_fills();
		test_stream_bypass();
		wait_idle();
		write_threshold(4'd0);
		test_random_traffic(150);
		wait_idle();
		write_threshold(4'd15);
		test_random_traffic(150);
		wait_idle();
		write_threshold(4'd3);
		test_random_traffic(150);
		wait_idle();

		$display("covered %0d transfers, %0d results, %0d streaming, %0d bypassed",
			items_sent, verdicts_seen, streams_seen, bypasses_seen);
		$display("thresholds 8, 0, 15 and 3 were used");
		if (errors == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
